### rtl/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// Types, constants and the skip pattern table of the frame skip governor.
// ----------------------------------------------------------------------------
package fsg_pkg;

	localparam int SKIP_LEVELS = 12;

	localparam logic [3:0] LEVEL_MAX      = 4'(SKIP_LEVELS - 1);
	localparam logic [3:0] PHASE_MAX      = 4'(SKIP_LEVELS - 1);
	localparam logic [3:0] LEVEL_SLOW_CAP = 4'd8;

	// speed thresholds in tenths of a percent
	localparam logic [15:0] SPEED_FULL = 16'd995;
	localparam logic [15:0] SPEED_SLOW = 16'd800;
	localparam logic [9:0]  SPEED_REF  = 10'd900;

	// x / 50 for x <= 900 as (x * 1311) >> 16
	localparam logic [10:0] RECIP_50    = 11'd1311;
	localparam int          RECIP_SHIFT = 16;

	localparam logic signed [5:0] DEBT_RAISE = -6'sd2;
	localparam logic signed [5:0] DEBT_DROP  = 6'sd3;
	localparam logic signed [5:0] DEBT_STEP  = 6'sd2;

	// configuration register indexes
	localparam logic [1:0] CFG_START_LEVEL    = 2'd0;
	localparam logic [1:0] CFG_START_AUTO     = 2'd1;
	localparam logic [1:0] CFG_START_THROTTLE = 2'd2;

	typedef struct packed {
		logic        frame_drawn;
		logic [15:0] speed_tenths;
		logic        warmed_up;
		logic        paused;
		logic        button_up;
		logic        button_down;
		logic        button_throttle;
	} fsg_in_t;

	typedef struct packed {
		logic       skip_next;
		logic [3:0] level_now;
		logic       auto_now;
		logic       throttle_now;
		logic [3:0] phase_now;
	} fsg_out_t;

	// one row per level, bit n is phase n
	localparam logic [11:0] SKIP_PATTERN [SKIP_LEVELS] = '{
		12'b000000000000,
		12'b100000000000,
		12'b100000100000,
		12'b100010001000,
		12'b100100100100,
		12'b101001010010,
		12'b101010101010,
		12'b101101011010,
		12'b110110110110,
		12'b111011101110,
		12'b111110111110,
		12'b111111111110
	};

	function automatic logic skip_bit(input logic [3:0] level, input logic [3:0] phase);
		logic [11:0] row;
		row = '0;
		if (level <= LEVEL_MAX) begin
			row = SKIP_PATTERN[level];
		end
		return (phase <= PHASE_MAX) ? row[phase] : 1'b0;
	endfunction

endpackage

### rtl/frame_skip_governor_core.sv
// ----------------------------------------------------------------------------
// frame_skip_governor_core
// Per-frame skip decision with automatic level control from measured speed.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, in_item (fsg_in_t)    | into block
//  out     | out_valid, out_ready, out_item (fsg_out_t)| out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
//  An item passes ADJUST, then NORM (one level raise per pass while the debt
//  is at or below -2), then FINISH; the debt/level adder loop sets how long it takes.
//  in_ready is high only while the sequencer is idle; one item at a time.
//  A finished result sits in the output register; the block takes a new
//  transfer meanwhile and stalls only at its last step if that register is full.
//  Reset loads level 0, auto mode on, throttle on, phase 0, debt 0.
//  Configuration writes are always taken and load the live state at once.

module frame_skip_governor_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fsg_pkg::fsg_in_t     in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fsg_pkg::fsg_out_t    out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [3:0]           cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ADJUST = 4'b0010,
		ST_NORM   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t            state_q;
	fsg_pkg::fsg_in_t  item_q;
	logic [3:0]        level_q;
	logic              auto_q;
	logic              throttle_q;
	logic [3:0]        phase_q;
	logic signed [5:0] debt_q;
	logic              was_paused_q;
	logic              out_valid_q;
	fsg_pkg::fsg_out_t out_q;

	logic              in_xfer;
	logic              cfg_xfer;
	logic              out_free;
	logic              try_adjust;
	logic              was_paused_eff;
	logic [9:0]        slow_diff;
	logic [20:0]       recip_prod;
	logic [4:0]        slow_quot;
	logic signed [5:0] debt_inc;
	logic signed [5:0] debt_slow;
	logic [3:0]        phase_next;
	logic [3:0]        btn_level;
	logic              btn_auto;
	logic [3:0]        up_level;
	logic              up_auto;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// adjustment gate and pause-aware skip
	assign try_adjust = item_q.frame_drawn && throttle_q && auto_q && (phase_q == '0);
	assign was_paused_eff = was_paused_q || item_q.paused;

	// slow-speed debt drop: (900 - speed) / 50 via reciprocal multiply
	assign slow_diff  = fsg_pkg::SPEED_REF - item_q.speed_tenths[9:0];
	assign recip_prod = 21'(slow_diff) * 21'(fsg_pkg::RECIP_50);
	assign slow_quot  = recip_prod[fsg_pkg::RECIP_SHIFT +: 5];
	assign debt_inc   = debt_q + 6'sd1;
	assign debt_slow  = debt_q - $signed({1'b0, slow_quot});

	assign phase_next = (phase_q == fsg_pkg::PHASE_MAX) ? 4'd0 : phase_q + 4'd1;

	// user buttons, up first then down
	always_comb begin
		up_level = level_q;
		up_auto  = auto_q;
		if (item_q.button_up) begin
			if (auto_q) begin
				up_auto  = 1'b0;
				up_level = 4'd0;
			end else if (level_q == fsg_pkg::LEVEL_MAX) begin
				up_auto  = 1'b1;
				up_level = 4'd0;
			end else begin
				up_level = level_q + 4'd1;
			end
		end
		btn_level = up_level;
		btn_auto  = up_auto;
		if (item_q.button_down) begin
			if (up_auto) begin
				btn_auto  = 1'b0;
				btn_level = fsg_pkg::LEVEL_MAX;
			end else if (up_level == 4'd0) begin
				btn_auto = 1'b1;
			end else begin
				btn_level = up_level - 4'd1;
			end
		end
	end

	// input capture register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q <= in_item;
		end
	end

	// sequencer and governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			level_q      <= 4'd0;
			auto_q       <= 1'b1;
			throttle_q   <= 1'b1;
			phase_q      <= 4'd0;
			debt_q       <= 6'sd0;
			was_paused_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_ADJUST;
					end
				end
				ST_ADJUST: begin
					if (try_adjust) begin
						was_paused_q <= item_q.paused;
						if (!was_paused_eff && item_q.warmed_up) begin
							if (item_q.speed_tenths >= fsg_pkg::SPEED_FULL) begin
								if (debt_inc >= fsg_pkg::DEBT_DROP) begin
									debt_q <= 6'sd0;
									if (level_q != 4'd0) begin
										level_q <= level_q - 4'd1;
									end
								end else begin
									debt_q <= debt_inc;
								end
							end else if (item_q.speed_tenths < fsg_pkg::SPEED_SLOW) begin
								debt_q <= debt_slow;
							end else if (level_q < fsg_pkg::LEVEL_SLOW_CAP) begin
								debt_q <= debt_q - 6'sd1;
							end
						end
					end else begin
						was_paused_q <= was_paused_eff;
					end
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					// one level raise per cycle, up to LEVEL_MAX, while debt is at or below -2
					if (debt_q <= fsg_pkg::DEBT_RAISE) begin
						debt_q <= debt_q + fsg_pkg::DEBT_STEP;
						if (level_q < fsg_pkg::LEVEL_MAX) begin
							level_q <= level_q + 4'd1;
						end
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						phase_q    <= phase_next;
						level_q    <= btn_level;
						auto_q     <= btn_auto;
						throttle_q <= throttle_q ^ item_q.button_throttle;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// configuration loads the live state directly
			if (cfg_xfer) begin
				unique case (cfg_index)
					fsg_pkg::CFG_START_LEVEL: begin
						level_q <= (cfg_data > fsg_pkg::LEVEL_MAX) ?
							fsg_pkg::LEVEL_MAX : cfg_data;
					end
					fsg_pkg::CFG_START_AUTO: begin
						auto_q <= cfg_data[0];
					end
					fsg_pkg::CFG_START_THROTTLE: begin
						throttle_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_q.skip_next    <= fsg_pkg::skip_bit(btn_level, phase_next);
			out_q.level_now    <= btn_level;
			out_q.auto_now     <= btn_auto;
			out_q.throttle_now <= throttle_q ^ item_q.button_throttle;
			out_q.phase_now    <= phase_next;
		end
	end

endmodule

### tb/frame_skip_governor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_skip_governor_core_tb
// Drives frames with valid/ready under random bursts and output stalls; checks
// every result against an in-bench skip governor model (the first directed
// frames against hand-known values) across several start-up register settings.
// ----------------------------------------------------------------------------
module frame_skip_governor_core_tb;

	localparam int DIR_ROWS         = 25;
	localparam int TYPED_ROWS       = 5;
	localparam int PHASES           = 7;
	localparam int FRAMES_PER_PHASE = 250;
	localparam int SETTLE_CYCLES    = 16;
	localparam int CYCLE_LIMIT      = 400000;

	// index with no register behind it
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// governor constants, speed in tenths of a percent
	localparam int FULL_SPEED     = 995;
	localparam int SLOW_SPEED     = 800;
	localparam int SPEED_BASE     = 900;
	localparam int SPEED_DIV      = 50;
	localparam int NEAR_LEVEL_CAP = 8;
	localparam int FAST_RUN       = 3;
	localparam int RAISE_DEBT     = 2;
	localparam int TOP_LEVEL      = 11;
	localparam int LAST_PHASE     = 11;

	// skip pattern per level, bit n set means skip at phase n
	localparam logic [11:0] SKIP_ROWS [12] = '{
		12'h000, 12'h800, 12'h820, 12'h888, 12'h924, 12'hA52,
		12'hAAA, 12'hB5A, 12'hDB6, 12'hEEE, 12'hFBE, 12'hFFE
	};

	typedef enum {BAND_FAST, BAND_NEAR, BAND_SLOW, BAND_ANY} speed_band_t;
	typedef enum {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_LONG_STALL} ready_mode_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	fsg_pkg::fsg_in_t  in_item;
	logic              out_valid;
	logic              out_ready;
	fsg_pkg::fsg_out_t out_item;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [3:0]        cfg_data;

	// governor model state
	int cur_level;
	bit cur_auto;
	bit cur_throttle;
	int cur_phase;
	int speed_debt;
	bit was_paused_q;
	bit is_paused_q;

	fsg_pkg::fsg_out_t pending_results [$];
	int                mismatches = 0;
	int unsigned       cycle_count = 0;
	int                burst_left;

	// directed frames: drawn, speed, warmed, paused, up, down, throttle
	fsg_pkg::fsg_in_t dir_stim [DIR_ROWS] = '{
		'{1'b1, 16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, 16'd65535, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 16'd0,     1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b1, 16'd1000,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b0, 16'd0,     1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 16'd995,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 16'd994,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 16'd65535, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 16'd800,   1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b1, 16'd799,   1'b1, 1'b0, 1'b0, 1'b1, 1'b1},
		'{1'b1, 16'd0,     1'b1, 1'b1, 1'b0, 1'b1, 1'b1},
		'{1'b1, 16'd65535, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd0,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd995,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd994,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, 16'h5555,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd800,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd799,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'hAAAA,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'h5555,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b1, 16'd1000,  1'b1, 1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 16'd0,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd1000,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd1000,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 16'd0,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	// results known by hand after reset: skip, level, auto, throttle, phase
	fsg_pkg::fsg_out_t dir_want [TYPED_ROWS] = '{
		'{1'b0, 4'd0,  1'b1, 1'b1, 4'd1},
		'{1'b0, 4'd0,  1'b0, 1'b1, 4'd2},
		'{1'b0, 4'd0,  1'b1, 1'b1, 4'd3},
		'{1'b1, 4'd11, 1'b0, 1'b1, 4'd4},
		'{1'b0, 4'd0,  1'b1, 1'b1, 4'd5}
	};

	// start-up settings per phase
	logic [3:0] phase_level [PHASES] = '{4'd0, 4'd11, 4'd15, 4'd5, 4'd12, 4'd3, 4'd8};
	bit         phase_auto  [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
	bit         phase_thr   [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

	frame_skip_governor_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// one frame through the governor, returns the expected result
	function automatic fsg_pkg::fsg_out_t predict_frame(input fsg_pkg::fsg_in_t f);
		fsg_pkg::fsg_out_t r;
		is_paused_q = f.paused;
		if (f.paused) was_paused_q = 1'b1;
		// level control at the start of each skip cycle
		if (f.frame_drawn && cur_throttle && cur_auto && cur_phase == 0) begin
			if (!was_paused_q && f.warmed_up) begin
				if (f.speed_tenths >= FULL_SPEED) begin
					speed_debt++;
					if (speed_debt >= FAST_RUN) begin
						speed_debt = 0;
						if (cur_level > 0) cur_level--;
					end
				end else begin
					if (f.speed_tenths < SLOW_SPEED)
						speed_debt -= (SPEED_BASE - int'(f.speed_tenths)) / SPEED_DIV;
					else if (cur_level < NEAR_LEVEL_CAP)
						speed_debt--;
					while (speed_debt <= -RAISE_DEBT) begin
						speed_debt += RAISE_DEBT;
						if (cur_level < TOP_LEVEL) cur_level++;
					end
				end
			end
			was_paused_q = is_paused_q;
		end
		cur_phase = (cur_phase == LAST_PHASE) ? 0 : cur_phase + 1;
		// user buttons: up, then down, then throttle
		if (f.button_up) begin
			if (cur_auto) begin
				cur_auto = 1'b0;
				cur_level = 0;
			end else if (cur_level == TOP_LEVEL) begin
				cur_level = 0;
				cur_auto = 1'b1;
			end else begin
				cur_level++;
			end
		end
		if (f.button_down) begin
			if (cur_auto) begin
				cur_auto = 1'b0;
				cur_level = TOP_LEVEL;
			end else if (cur_level == 0) begin
				cur_auto = 1'b1;
			end else begin
				cur_level--;
			end
		end
		if (f.button_throttle) cur_throttle = !cur_throttle;
		r.skip_next    = SKIP_ROWS[cur_level][cur_phase];
		r.level_now    = 4'(cur_level);
		r.auto_now     = cur_auto;
		r.throttle_now = cur_throttle;
		r.phase_now    = 4'(cur_phase);
		return r;
	endfunction

	// random frame; outside noise runs the buttons steer back to auto mode
	function automatic fsg_pkg::fsg_in_t random_frame(input speed_band_t band);
		fsg_pkg::fsg_in_t f;
		f.frame_drawn = ($urandom_range(0, 7) != 0);
		f.warmed_up   = ($urandom_range(0, 15) != 0);
		f.paused      = ($urandom_range(0, 23) == 0);
		case (band)
			BAND_FAST: begin
				if ($urandom_range(0, 3) == 0)
					f.speed_tenths = 16'($urandom_range(FULL_SPEED, 65535));
				else
					f.speed_tenths = 16'($urandom_range(FULL_SPEED, 1010));
			end
			BAND_NEAR: f.speed_tenths = 16'($urandom_range(SLOW_SPEED, FULL_SPEED - 1));
			BAND_SLOW: begin
				if ($urandom_range(0, 3) != 0)
					f.speed_tenths = 16'($urandom_range(700, SLOW_SPEED - 1));
				else
					f.speed_tenths = 16'($urandom_range(0, SLOW_SPEED - 1));
			end
			default: f.speed_tenths = 16'($urandom_range(0, 65535));
		endcase
		if (band == BAND_ANY) begin
			f.frame_drawn     = 1'($urandom_range(0, 1));
			f.warmed_up       = 1'($urandom_range(0, 1));
			f.paused          = ($urandom_range(0, 3) == 0);
			f.button_up       = ($urandom_range(0, 3) == 0);
			f.button_down     = ($urandom_range(0, 3) == 0);
			f.button_throttle = ($urandom_range(0, 3) == 0);
		end else if (!cur_auto) begin
			f.button_down     = ($urandom_range(0, 3) == 0);
			f.button_up       = (cur_level == TOP_LEVEL) && ($urandom_range(0, 3) == 0);
			f.button_throttle = cur_throttle ? ($urandom_range(0, 119) == 0)
				: ($urandom_range(0, 7) == 0);
		end else begin
			f.button_up       = ($urandom_range(0, 79) == 0);
			f.button_down     = ($urandom_range(0, 79) == 0);
			f.button_throttle = cur_throttle ? ($urandom_range(0, 119) == 0)
				: ($urandom_range(0, 7) == 0);
		end
		return f;
	endfunction

	// one input transfer, then a gap at the end of a burst
	task automatic send_frame(input fsg_pkg::fsg_in_t f, input bit typed,
			input fsg_pkg::fsg_out_t typed_want);
		fsg_pkg::fsg_out_t guess;
		in_item  <= f;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		guess = predict_frame(f);
		pending_results.push_back(typed ? typed_want : guess);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(16, 80);
		end else begin
			burst_left--;
		end
	endtask

	// stop sending until every result is back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// register write transfer; the live state follows at once
	task automatic write_register(input logic [1:0] idx, input logic [3:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fsg_pkg::CFG_START_LEVEL:
				cur_level = (data > TOP_LEVEL) ? TOP_LEVEL : int'(data);
			fsg_pkg::CFG_START_AUTO:     cur_auto = data[0];
			fsg_pkg::CFG_START_THROTTLE: cur_throttle = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// compare each output transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		fsg_pkg::fsg_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, out_item);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("skip_next", 16'(want.skip_next), 16'(out_item.skip_next));
				check_field("level_now", 16'(want.level_now), 16'(out_item.level_now));
				check_field("auto_now", 16'(want.auto_now), 16'(out_item.auto_now));
				check_field("throttle_now", 16'(want.throttle_now), 16'(out_item.throttle_now));
				check_field("phase_now", 16'(want.phase_now), 16'(out_item.phase_now));
			end
		end
	end

	// output stalls in stretches of different shape
	initial begin : drive_out_ready
		ready_mode_t mode;
		int span;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = ready_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 160);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					READY_ALWAYS:  out_ready <= 1'b1;
					READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
					READY_PATTERN: out_ready <= ((k % 5) != 4);
					default:       out_ready <= ((k % 24) >= 20);
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL frame_skip_governor_core");
			$finish;
		end
	end

	initial begin : stimulus
		speed_band_t band;
		int run_left;
		int pick;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = fsg_pkg::CFG_START_LEVEL;
		cfg_data  = 4'd0;
		arst_n    = 1'b0;
		// state after reset
		cur_level    = 0;
		cur_auto     = 1'b1;
		cur_throttle = 1'b1;
		cur_phase    = 0;
		speed_debt   = 0;
		was_paused_q = 1'b0;
		is_paused_q  = 1'b0;
		burst_left   = 0;
		band         = BAND_FAST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed frames from the reset state
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i < TYPED_ROWS)
				send_frame(dir_stim[i], 1'b1, dir_want[i]);
			else
				send_frame(dir_stim[i], 1'b0, '0);
		end

		// random frames under several start-up settings
		for (int p = 0; p < PHASES; p++) begin
			hold_until_drained();
			repeat (SETTLE_CYCLES) @(negedge clk);
			write_register(fsg_pkg::CFG_START_LEVEL, phase_level[p]);
			write_register(fsg_pkg::CFG_START_AUTO,
				{3'($urandom_range(0, 7)), phase_auto[p]});
			write_register(fsg_pkg::CFG_START_THROTTLE,
				{3'($urandom_range(0, 7)), phase_thr[p]});
			if (p == 3) write_register(CFG_UNUSED, 4'($urandom_range(0, 15)));
			run_left = 0;
			for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
				if (run_left == 0) begin
					pick = $urandom_range(0, 19);
					if (pick < 9)       band = BAND_FAST;
					else if (pick < 14) band = BAND_NEAR;
					else if (pick < 17) band = BAND_SLOW;
					else                band = BAND_ANY;
					run_left = $urandom_range(24, 72);
				end
				run_left--;
				send_frame(random_frame(band), 1'b0, '0);
				if (n == FRAMES_PER_PHASE / 2) hold_until_drained();
			end
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS frame_skip_governor_core");
		else
			$display("FAIL frame_skip_governor_core");
		$finish;
	end

endmodule

### files.f
rtl/fsg_pkg.sv
rtl/frame_skip_governor_core.sv
tb/frame_skip_governor_core_tb.sv
